[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker files of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge while out of reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition implies a result on the next rising clk edge.
`define ASSERT_NEXT(label, cond, result) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
        else $error("assertion failed");

`endif

[hdl/pce_pkg.sv]
// ----------------------------------------------------------------------------
// pce_pkg
// Types, constants and helper functions of the pixel color effect block.
// ----------------------------------------------------------------------------
`default_nettype none

package pce_pkg;

    // Pixel and channel widths
    localparam int PIXEL_W = 24;
    localparam int CHAN_W  = 8;
    localparam int SUM_W   = 10;
    localparam int MODE_W  = 4;

    // Channel levels
    localparam logic [CHAN_W-1:0] CH_MAX  = 8'hFF;
    localparam logic [CHAN_W-1:0] CH_ZERO = 8'h00;

    // Divide by three: floor(s / 3) == (s * 683) >> 11 for s up to 765
    localparam int PROD_W = 20;
    localparam logic [PROD_W-1:0] DIV3_RECIP = 20'd683;
    localparam int DIV3_SHIFT = 11;

    // Effect codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PASS       = 4'd0,
        MODE_NEGATIVE   = 4'd1,
        MODE_GREY       = 4'd2,
        MODE_TINT_BLUE  = 4'd3,
        MODE_TINT_GREEN = 4'd4,
        MODE_TINT_RED   = 4'd5,
        MODE_BW         = 4'd6,
        MODE_THRESHOLD  = 4'd7,
        MODE_AVG_RED    = 4'd8,
        MODE_AVG_GREEN  = 4'd9,
        MODE_AVG_BLUE   = 4'd10
    } mode_t;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [CHAN_W-1:0]  chan_t;

    // Average of three channel sum, by reciprocal multiply
    function automatic chan_t div3(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] prod;
        prod = {{(PROD_W-SUM_W){1'b0}}, s} * DIV3_RECIP;
        return prod[DIV3_SHIFT +: CHAN_W];
    endfunction

    // Full on at or above half scale, else off
    function automatic chan_t level(input chan_t c);
        return c[CHAN_W-1] ? CH_MAX : CH_ZERO;
    endfunction

    function automatic chan_t pick_max(input chan_t a, input chan_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic chan_t pick_min(input chan_t a, input chan_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

[hdl/pce_in_stage.sv]
// ----------------------------------------------------------------------------
// pce_in_stage
// Input register: captures one pixel per transfer and hands it downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module pce_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire pce_pkg::pixel_t pixel_in,
    output logic                 s1_valid,
    input  wire logic            s1_ready,
    output pce_pkg::pixel_t      s1_pixel
);

    logic            valid_reg;
    logic            valid_next;
    pce_pkg::pixel_t pixel_reg;

    // Take a new pixel when empty or when the held one moves on
    assign in_ready = !valid_reg || s1_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload on transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pixel_reg <= pixel_in;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_pixel = pixel_reg;

endmodule

`default_nettype wire

[hdl/pce_effect.sv]
// ----------------------------------------------------------------------------
// pce_effect
// Combinational color effect: pass, average, tint, threshold or negative per mode.
// ----------------------------------------------------------------------------
`default_nettype none

module pce_effect (
    input  wire logic [pce_pkg::MODE_W-1:0] effect_mode,
    input  wire pce_pkg::pixel_t            pixel_src,
    output pce_pkg::pixel_t                 pixel_fx
);

    pce_pkg::chan_t                  r;
    pce_pkg::chan_t                  g;
    pce_pkg::chan_t                  b;
    logic [pce_pkg::SUM_W-1:0]       sum;
    pce_pkg::chan_t                  avg;
    pce_pkg::chan_t                  nr;
    pce_pkg::chan_t                  ng;
    pce_pkg::chan_t                  nb;

    // Split channels and form the average
    assign r   = pixel_src[23:16];
    assign g   = pixel_src[15:8];
    assign b   = pixel_src[7:0];
    assign sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
    assign avg = pce_pkg::div3(sum);

    // Select the effect
    always_comb
    begin
        nr = r;
        ng = g;
        nb = b;
        case (pce_pkg::mode_t'(effect_mode))
            pce_pkg::MODE_NEGATIVE:
            begin
                nr = pce_pkg::CH_MAX - r;
                ng = pce_pkg::CH_MAX - g;
                nb = pce_pkg::CH_MAX - b;
            end
            pce_pkg::MODE_GREY:
            begin
                nr = avg;
                ng = avg;
                nb = avg;
            end
            pce_pkg::MODE_TINT_BLUE:
            begin
                nb = pce_pkg::pick_max(b, avg);
                nr = pce_pkg::pick_min(b, avg);
                ng = pce_pkg::pick_min(b, avg);
            end
            pce_pkg::MODE_TINT_GREEN:
            begin
                ng = pce_pkg::pick_max(g, avg);
                nr = pce_pkg::pick_min(g, avg);
                nb = pce_pkg::pick_min(g, avg);
            end
            pce_pkg::MODE_TINT_RED:
            begin
                nr = pce_pkg::pick_max(r, avg);
                ng = pce_pkg::pick_min(r, avg);
                nb = pce_pkg::pick_min(r, avg);
            end
            pce_pkg::MODE_BW:
            begin
                nr = pce_pkg::level(avg);
                ng = pce_pkg::level(avg);
                nb = pce_pkg::level(avg);
            end
            pce_pkg::MODE_THRESHOLD:
            begin
                nr = pce_pkg::level(r);
                ng = pce_pkg::level(g);
                nb = pce_pkg::level(b);
            end
            pce_pkg::MODE_AVG_RED:
            begin
                nr = avg;
                ng = pce_pkg::CH_ZERO;
                nb = pce_pkg::CH_ZERO;
            end
            pce_pkg::MODE_AVG_GREEN:
            begin
                nr = pce_pkg::CH_ZERO;
                ng = avg;
                nb = pce_pkg::CH_ZERO;
            end
            pce_pkg::MODE_AVG_BLUE:
            begin
                nr = pce_pkg::CH_ZERO;
                ng = pce_pkg::CH_ZERO;
                nb = avg;
            end
            default:
            begin
                nr = r;
                ng = g;
                nb = b;
            end
        endcase
    end

    assign pixel_fx = {nr, ng, nb};

endmodule

`default_nettype wire

[hdl/pce_out_stage.sv]
// ----------------------------------------------------------------------------
// pce_out_stage
// Result register: holds the transformed pixel until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pce_out_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s1_valid,
    output logic                 s1_ready,
    input  wire pce_pkg::pixel_t pixel_fx,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output pce_pkg::pixel_t      pixel_out
);

    logic            valid_reg;
    logic            valid_next;
    pce_pkg::pixel_t pixel_reg;

    // Accept a result when empty or when the held one leaves this cycle
    assign s1_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (s1_ready)
        begin
            valid_next = s1_valid;
        end
    end

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the result on transfer, hold it while stalled
    always_ff @(posedge clk)
    begin
        if (s1_valid && s1_ready)
        begin
            pixel_reg <= pixel_fx;
        end
    end

    assign out_valid = valid_reg;
    assign pixel_out = pixel_reg;

endmodule

`default_nettype wire

[hdl/pixel_color_effect_top.sv]
// ----------------------------------------------------------------------------
// pixel_color_effect_top
// Per-pixel color effect on a 24-bit RGB stream (red 23:16, blue 7:0).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/pixel_in carries one pixel per transfer;
//   output channel out_valid/out_ready/pixel_out carries one result pixel
//   per input pixel, in order.
//   effect_mode is written at any rising edge with effect_mode_wr_en high;
//   change it only while no pixel is in flight.
//   Path: a pixel taken by the input register passes through the effect
//   logic into the result register, which drives out_valid and pixel_out.
//   Throughput: one pixel per cycle while out_ready stays high. The effect
//   logic path is one sum of three channels, a 10x10 multiply by the
//   reciprocal of three and an 11-way select, into the result register.
//   Stall: when out_ready is low the result register holds; the input
//   register still takes one more pixel if it is empty, then in_ready drops until the
//   receiver resumes. No pixel is dropped or repeated.
//   Reset: rst_n low empties both registers and sets effect_mode to pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_color_effect_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [23:0]                 pixel_in,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [23:0]                      pixel_out,
    input  wire logic                        effect_mode_wr_en,
    input  wire logic [pce_pkg::MODE_W-1:0]  effect_mode
);

    logic [pce_pkg::MODE_W-1:0] mode_reg;
    logic                       s1_valid;
    logic                       s1_ready;
    pce_pkg::pixel_t            s1_pixel;
    pce_pkg::pixel_t            pixel_fx;

    // Hold the effect mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= pce_pkg::MODE_PASS;
        end
        else if (effect_mode_wr_en)
        begin
            mode_reg <= effect_mode;
        end
    end

    // Input register
    pce_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .pixel_in (pixel_in),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_pixel (s1_pixel)
    );

    // Effect logic
    pce_effect u_effect (
        .effect_mode (mode_reg),
        .pixel_src   (s1_pixel),
        .pixel_fx    (pixel_fx)
    );

    // Result register
    pce_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .pixel_fx  (pixel_fx),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out)
    );

endmodule

`default_nettype wire

[hdl/pce_checker.sv]
// ----------------------------------------------------------------------------
// pce_checker
// Port-level checks of the pixel color effect block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pce_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [23:0] pixel_in,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [23:0] pixel_out
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    // A waiting input pixel stays put until it is taken
    `ASSERT_NEXT(a_in_pixel_hold, in_valid && !in_ready, $stable(pixel_in))

    // A stalled result keeps its valid
    `ASSERT_NEXT(a_out_valid_hold, out_valid && !out_ready, out_valid)

    // A stalled result keeps its pixel
    `ASSERT_NEXT(a_out_pixel_hold, out_valid && !out_ready, $stable(pixel_out))

    // With the result register empty the block always takes a pixel
    `ASSERT_CLK(a_ready_when_empty, !out_valid |-> in_ready)

    // A result appears only for a pixel transferred in and passed on from the input register
    `ASSERT_CLK(a_result_has_source, $rose(out_valid) |-> $past(in_xfer, 2))

endmodule

bind pixel_color_effect_top pce_checker u_pce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out)
);

`default_nettype wire

[sim/pixel_effect_checker.sv]
// ----------------------------------------------------------------------------
// pixel_effect_checker
// Watches both pixel channels and the mode write port of the color effect
// block, predicts each result pixel and compares it with the output.
// ----------------------------------------------------------------------------
module pixel_effect_checker
    import pce_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  pixel_t              pixel_in,
    input  logic                out_valid,
    input  logic                out_ready,
    input  pixel_t              pixel_out,
    input  logic                effect_mode_wr_en,
    input  logic [MODE_W-1:0]   effect_mode,
    output int                  fail_count,
    output int                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam chan_t HALF_SCALE = 8'd128;
    localparam chan_t FULL_SCALE = 8'd255;

    logic [MODE_W-1:0] active_mode;
    pixel_t            expected_pixels[$];

    // Full on at or above half scale
    function automatic chan_t binarize(input chan_t c);
        return (c >= HALF_SCALE) ? FULL_SCALE : 8'd0;
    endfunction

    // Work out the result pixel for one source pixel under a given mode
    function automatic pixel_t apply_effect(input logic [MODE_W-1:0] m, input pixel_t p);
        chan_t          r;
        chan_t          g;
        chan_t          b;
        chan_t          avg;
        chan_t          nr;
        chan_t          ng;
        chan_t          nb;
        chan_t          hi;
        chan_t          lo;
        logic [9:0]     sum;
        r   = p[23:16];
        g   = p[15:8];
        b   = p[7:0];
        sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
        avg = chan_t'(sum / 10'd3);
        nr  = r;
        ng  = g;
        nb  = b;
        case (m)
            MODE_NEGATIVE:
            begin
                nr = FULL_SCALE - r;
                ng = FULL_SCALE - g;
                nb = FULL_SCALE - b;
            end
            MODE_GREY:
            begin
                nr = avg;
                ng = avg;
                nb = avg;
            end
            MODE_TINT_BLUE:
            begin
                hi = (b > avg) ? b : avg;
                lo = (b < avg) ? b : avg;
                nb = hi;
                nr = lo;
                ng = lo;
            end
            MODE_TINT_GREEN:
            begin
                hi = (g > avg) ? g : avg;
                lo = (g < avg) ? g : avg;
                ng = hi;
                nr = lo;
                nb = lo;
            end
            MODE_TINT_RED:
            begin
                hi = (r > avg) ? r : avg;
                lo = (r < avg) ? r : avg;
                nr = hi;
                ng = lo;
                nb = lo;
            end
            MODE_BW:
            begin
                nr = binarize(avg);
                ng = nr;
                nb = nr;
            end
            MODE_THRESHOLD:
            begin
                nr = binarize(r);
                ng = binarize(g);
                nb = binarize(b);
            end
            MODE_AVG_RED:
            begin
                nr = avg;
                ng = 8'd0;
                nb = 8'd0;
            end
            MODE_AVG_GREEN:
            begin
                nr = 8'd0;
                ng = avg;
                nb = 8'd0;
            end
            MODE_AVG_BLUE:
            begin
                nr = 8'd0;
                ng = 8'd0;
                nb = avg;
            end
            default:
            begin
                // pass through, unknown modes included
            end
        endcase
        return {nr, ng, nb};
    endfunction

    // Track the mode, queue predictions on input transfers, check output transfers
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            active_mode = MODE_PASS;
            expected_pixels.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: output pixel %06h with none expected, expected none",
                             $time, pixel_out);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_out !== want)
                    begin
                        $display("%0t: pixel_out mismatch, expected %06h, actual %06h",
                                 $time, want, pixel_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_pixels.push_back(apply_effect(active_mode, pixel_in));
            if (effect_mode_wr_en)
                active_mode = effect_mode;
            pending_count <= expected_pixels.size();
        end
    end

endmodule

[sim/pixel_color_effect_top_tb.sv]
// ----------------------------------------------------------------------------
// pixel_color_effect_top_tb
// Drives pixels through the color effect block under every mode, with random
// gaps on the sender and stalls on the receiver, and reports the verdict.
// ----------------------------------------------------------------------------
module pixel_color_effect_top_tb;
    import pce_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 12;
    localparam int RANDOM_PHASES = 35;
    localparam int PHASE_PIXELS  = 50;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LIMIT_CYCLES  = 600000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    pixel_t              pixel_in;
    logic                out_valid;
    logic                out_ready;
    pixel_t              pixel_out;
    logic                effect_mode_wr_en;
    logic [MODE_W-1:0]   effect_mode;
    int                  fail_count;
    int                  pending_count;

    // No random gaps on either side while set; the periodic receiver hold-off still applies
    logic                steady;
    int                  hold_left;
    int                  rx_cycles;

    pixel_color_effect_top uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .pixel_in          (pixel_in),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pixel_out         (pixel_out),
        .effect_mode_wr_en (effect_mode_wr_en),
        .effect_mode       (effect_mode)
    );

    pixel_effect_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .pixel_in          (pixel_in),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pixel_out         (pixel_out),
        .effect_mode_wr_en (effect_mode_wr_en),
        .effect_mode       (effect_mode),
        .fail_count        (fail_count),
        .pending_count     (pending_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("FAILURE");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 50);
    endfunction

    // Pick a channel value from the extremes and the half-scale edge
    function automatic chan_t corner_channel();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd127;
            3:       return 8'd128;
            default: return chan_t'($urandom);
        endcase
    endfunction

    // Random source pixel, weighted toward the threshold and average edges
    function automatic pixel_t random_pixel();
        chan_t r;
        chan_t g;
        int    target;
        case ($urandom_range(0, 9))
            5:
                return {corner_channel(), corner_channel(), corner_channel()};
            6, 7:
                return {chan_t'($urandom_range(120, 135)), chan_t'($urandom_range(120, 135)),
                        chan_t'($urandom_range(120, 135))};
            8:
            begin
                // put the channel sum around the black-and-white edge
                r      = chan_t'($urandom_range(70, 190));
                g      = chan_t'($urandom_range(70, 190));
                target = $urandom_range(380, 387);
                return {r, g, chan_t'(target - int'(r) - int'(g))};
            end
            9:
            begin
                r = chan_t'($urandom);
                return {r, r, r};
            end
            default:
                return pixel_t'($urandom);
        endcase
    endfunction

    // Offer one pixel and hold it until the transfer; call at a falling edge
    task automatic send_pixel(input pixel_t p);
        int gap;
        gap = steady ? 0 : gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= p;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Drain every pixel in flight, then write the mode register
    task automatic set_mode(input logic [MODE_W-1:0] m);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        effect_mode       <= m;
        effect_mode_wr_en <= 1'b1;
        @(negedge clk);
        effect_mode_wr_en <= 1'b0;
    endtask

    // Directed pixel under a given mode; write the mode only when it changes
    task automatic directed_pixel(input logic [MODE_W-1:0] m, input pixel_t p);
        if (m != effect_mode)
            set_mode(m);
        send_pixel(p);
    endtask

    // Receiver: random stalls, plus a long hold-off now and then to fill the block
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        rx_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycles++;
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (rx_cycles % 2500 == 1200)
            begin
                out_ready <= 1'b0;
                hold_left = 80;
            end
            else if (!steady && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                hold_left = gap_length();
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [MODE_W-1:0] phase_mode;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        pixel_in          = '0;
        effect_mode_wr_en = 1'b0;
        effect_mode       = MODE_PASS;
        steady            = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, every effect, threshold and average edges
        directed_pixel(MODE_PASS, 24'h000000);
        directed_pixel(MODE_PASS, 24'hFFFFFF);
        directed_pixel(MODE_NEGATIVE, 24'h00FF7F);
        directed_pixel(MODE_NEGATIVE, 24'hA5C3E1);
        directed_pixel(MODE_GREY, 24'hFFFFFF);
        directed_pixel(MODE_GREY, 24'h010000);
        directed_pixel(MODE_GREY, 24'h020100);
        directed_pixel(MODE_TINT_BLUE, 24'h0000FF);
        directed_pixel(MODE_TINT_BLUE, 24'hFFFF00);
        directed_pixel(MODE_TINT_GREEN, 24'h00FF00);
        directed_pixel(MODE_TINT_GREEN, 24'hFF00FF);
        directed_pixel(MODE_TINT_RED, 24'hFF0000);
        directed_pixel(MODE_TINT_RED, 24'h00FFFF);
        directed_pixel(MODE_BW, 24'h808080);
        directed_pixel(MODE_BW, 24'h7F7F7F);
        directed_pixel(MODE_BW, 24'h7F8080);
        directed_pixel(MODE_BW, 24'h81807F);
        directed_pixel(MODE_THRESHOLD, 24'h807F80);
        directed_pixel(MODE_THRESHOLD, 24'h7F807F);
        directed_pixel(MODE_AVG_RED, 24'hFFFFFF);
        directed_pixel(MODE_AVG_GREEN, 24'h123456);
        directed_pixel(MODE_AVG_BLUE, 24'hFFFEFD);
        // unknown modes pass the pixel through
        directed_pixel(4'd11, 24'h123456);
        directed_pixel(4'd15, 24'hABCDEF);

        // Random phases: every mode first, then random modes
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            phase_mode = (phase < 16) ? MODE_W'(phase) : MODE_W'($urandom_range(0, 15));
            set_mode(phase_mode);
            steady = (phase % 5 == 4);
            for (int i = 0; i < PHASE_PIXELS; i++)
                send_pixel(random_pixel());
        end

        // Drain and give the verdict
        in_valid <= 1'b0;
        steady   <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
